// ===== hdl/wns_pkg.sv =====
// shared types and constants for the weighted negative sampler
`default_nettype none

package wns_pkg;

   localparam int OP_W        = 2;
   localparam int WEIGHT_W    = 16;
   localparam int ITEM_W      = 10;
   localparam int RND_W       = 31;
   localparam int DIV_CNT_W   = $clog2(RND_W);
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_MARK   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_DRAW   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DIV,
      ST_SRCH_CHK,
      ST_SRCH_CMP,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/weighted_negative_sampler_unit.sv =====
// weighted negative sampler top level with cumulative table and positive bitmap
`default_nettype none

// Appends, marks and clear requests share one input stream; only draws produce a
// response. A draw runs the bit-serial remainder unit over the 31-bit random word,
// then a binary search over the cumulative table, in which every probe waits for the
// registered read of the cumulative table memory, then the bitmap read and the
// response register. A clear request, and reset itself, run a clearing pass over
// every entry of the positive bitmap memory, during which req_tready stays low.
// The response register frees the input side: a new request is taken while a response
// still waits on rsp_tready.
module weighted_negative_sampler_unit #(
   parameter int MAX_ITEMS        = 1024,
   parameter int WEIGHT_FRAC_BITS = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // weight[15:0], item_index[25:16], random_word[56:26], zero fill
   input  wire logic [wns_pkg::REQ_TDATA_W-1:0]       req_tdata,
   // opcode[1:0]
   input  wire logic [wns_pkg::OP_W-1:0]              req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // sampled_item[9:0], zero fill
   output logic [wns_pkg::RSP_TDATA_W-1:0]            rsp_tdata,
   // rejected[0], error[1]
   output logic [wns_pkg::RSP_TUSER_W-1:0]            rsp_tuser
);

   localparam int IDX_W   = $clog2(MAX_ITEMS);
   localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
   localparam int TOT_W   = wns_pkg::WEIGHT_W + IDX_W;
   localparam int INT_W   = TOT_W - WEIGHT_FRAC_BITS;
   localparam int ITEM_W  = wns_pkg::ITEM_W;
   localparam int RND_W   = wns_pkg::RND_W;
   localparam int DCNT_W  = wns_pkg::DIV_CNT_W;

   // memories
   logic [TOT_W-1:0] cum_mem [MAX_ITEMS];
   logic             mark_mem [MAX_ITEMS];

   // registers
   wns_pkg::state_type  state_ff, state_in;
   logic [IDX_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [CNT_W-1:0]    loaded_ff, loaded_in;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic [RND_W-1:0]    rnd_ff, rnd_in;
   logic [INT_W-1:0]    rem_ff, rem_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;
   logic                err_ff, err_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ITEM_W-1:0]   rsp_item_ff, rsp_item_in;
   logic                rsp_rej_ff, rsp_rej_in;
   logic                rsp_err_ff, rsp_err_in;
   logic [TOT_W-1:0]    cum_rd_ff;
   logic                mark_rd_ff;

   // request fields
   wns_pkg::op_type             req_op;
   logic [wns_pkg::WEIGHT_W-1:0] req_weight;
   logic [ITEM_W-1:0]           req_item;
   logic [RND_W-1:0]            req_rnd;
   logic [IDX_W+ITEM_W-1:0]     req_item_ext;
   logic                        req_item_ok;

   // datapath
   logic [INT_W-1:0]    int_part;
   logic [INT_W:0]      div_shift;
   logic [INT_W:0]      div_sub;
   logic                div_ge;
   logic [INT_W-1:0]    div_rem;
   logic [TOT_W-1:0]    thr;
   logic [CNT_W-1:0]    span;
   logic [CNT_W-1:0]    mid;
   logic [CNT_W+ITEM_W-1:0] lo_ext;
   logic                table_full;

   // memory ports
   logic                cum_we;
   logic                mark_we;
   logic [IDX_W-1:0]    mark_waddr;
   logic                mark_wdata;

   assign req_op       = wns_pkg::op_type'(req_tuser);
   assign req_weight   = req_tdata[15:0];
   assign req_item     = req_tdata[25:16];
   assign req_rnd      = req_tdata[56:26];
   assign req_item_ext = {{IDX_W{1'b0}}, req_item};
   assign req_item_ok  = 32'(req_item) < MAX_ITEMS;

   assign int_part  = INT_W'(total_ff >> WEIGHT_FRAC_BITS);
   assign div_shift = {rem_ff, rnd_ff[RND_W-1]};
   assign div_ge    = div_shift >= {1'b0, int_part};
   assign div_sub   = div_shift - {1'b0, int_part};
   assign div_rem   = div_ge ? div_sub[INT_W-1:0] : div_shift[INT_W-1:0];
   assign thr       = TOT_W'(rem_ff) << WEIGHT_FRAC_BITS;

   assign span       = hi_ff - lo_ff;
   assign mid        = lo_ff + (span >> 1);
   assign lo_ext     = {{ITEM_W{1'b0}}, lo_ff};
   assign table_full = loaded_ff >= CNT_W'(MAX_ITEMS);

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      loaded_in    = loaded_ff;
      total_in     = total_ff;
      rnd_in       = rnd_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_item_in  = rsp_item_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_err_in   = rsp_err_ff;
      cum_we       = 1'b0;
      mark_we      = 1'b0;
      mark_waddr   = clr_cnt_ff;
      mark_wdata   = 1'b0;
      req_tready   = 1'b0;
      unique case (state_ff)
         wns_pkg::ST_CLEAR: begin
            mark_we    = 1'b1;
            mark_waddr = clr_cnt_ff;
            mark_wdata = 1'b0;
            clr_cnt_in = clr_cnt_ff + IDX_W'(1);
            if (clr_cnt_ff == IDX_W'(MAX_ITEMS - 1)) begin
               state_in = wns_pkg::ST_IDLE;
            end
         end
         wns_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (req_op)
                  wns_pkg::OP_APPEND: begin
                     if (!table_full) begin
                        cum_we    = 1'b1;
                        total_in  = total_ff + TOT_W'(req_weight);
                        loaded_in = loaded_ff + CNT_W'(1);
                     end
                  end
                  wns_pkg::OP_MARK: begin
                     mark_we    = req_item_ok;
                     mark_waddr = req_item_ext[IDX_W-1:0];
                     mark_wdata = 1'b1;
                  end
                  wns_pkg::OP_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = wns_pkg::ST_CLEAR;
                  end
                  wns_pkg::OP_DRAW: begin
                     rnd_in  = req_rnd;
                     rem_in  = '0;
                     dcnt_in = DCNT_W'(RND_W - 1);
                     if (int_part == '0) begin
                        err_in   = 1'b1;
                        state_in = wns_pkg::ST_OUT;
                     end else begin
                        err_in   = 1'b0;
                        state_in = wns_pkg::ST_DIV;
                     end
                  end
               endcase
            end
         end
         wns_pkg::ST_DIV: begin
            rem_in  = div_rem;
            rnd_in  = rnd_ff << 1;
            dcnt_in = dcnt_ff - DCNT_W'(1);
            if (dcnt_ff == '0) begin
               lo_in    = '0;
               hi_in    = loaded_ff;
               state_in = wns_pkg::ST_SRCH_CHK;
            end
         end
         wns_pkg::ST_SRCH_CHK: begin
            if (span > CNT_W'(1)) begin
               state_in = wns_pkg::ST_SRCH_CMP;
            end else begin
               state_in = wns_pkg::ST_OUT;
            end
         end
         wns_pkg::ST_SRCH_CMP: begin
            if (cum_rd_ff <= thr) begin
               lo_in = mid;
            end else begin
               hi_in = mid;
            end
            state_in = wns_pkg::ST_SRCH_CHK;
         end
         wns_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = err_ff ? '0 : lo_ext[ITEM_W-1:0];
               rsp_rej_in   = err_ff ? 1'b0 : mark_rd_ff;
               rsp_err_in   = err_ff;
               state_in     = wns_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wns_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wns_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         loaded_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         loaded_ff    <= loaded_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff      <= rnd_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      err_ff      <= err_in;
      rsp_item_ff <= rsp_item_in;
      rsp_rej_ff  <= rsp_rej_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // cumulative table
   always_ff @(posedge clock) begin
      if (cum_we) begin
         cum_mem[loaded_ff[IDX_W-1:0]] <= total_ff;
      end
      cum_rd_ff <= cum_mem[mid[IDX_W-1:0]];
   end

   // positive bitmap
   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      mark_rd_ff <= mark_mem[lo_ff[IDX_W-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(wns_pkg::RSP_TDATA_W - ITEM_W){1'b0}}, rsp_item_ff};
   assign rsp_tuser  = {rsp_err_ff, rsp_rej_ff};

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0 && !rsp_tuser[0])
      else $error("error response carries an item or a reject");

   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= CNT_W'(MAX_ITEMS))
      else $error("loaded count beyond table depth");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == wns_pkg::ST_DIV |-> rem_ff < int_part)
      else $error("partial remainder not below divisor");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == wns_pkg::ST_SRCH_CMP |-> lo_ff < mid && mid < hi_ff)
      else $error("search probe outside its window");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("requests taken before bitmap clearing pass");

endmodule

`default_nettype wire
